@@ rtl/i2c_register_read_master_core_macros.svh @@
// assertion macros for the i2c register read master core
// used by i2c_register_read_master_core.sv, expects a clock named clk and reset rst
`ifndef I2C_REGISTER_READ_MASTER_CORE_MACROS_SVH
`define I2C_REGISTER_READ_MASTER_CORE_MACROS_SVH

// checked only outside reset
`define I2CRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define I2CRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/i2crr_pkg.sv @@
// shared constants, bus phase codes and line tables for the i2c register read master
// no dependencies
package i2crr_pkg;

  localparam int PHASE_W = 5;
  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_WRITE_PHASE_TICKS = 2'd2;
  localparam logic [1:0] REG_READ_PHASE_TICKS = 2'd3;

  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd72;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [7:0] WRITE_PHASE_TICKS_RST = 8'd1;
  localparam logic [7:0] READ_PHASE_TICKS_RST = 8'd5;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  // bus phases
  localparam logic [PHASE_W-1:0] P_IDLE = 5'd0;
  localparam logic [PHASE_W-1:0] P_ST_HI = 5'd1;
  localparam logic [PHASE_W-1:0] P_ST_LO = 5'd2;
  localparam logic [PHASE_W-1:0] P_TXW_L = 5'd3;
  localparam logic [PHASE_W-1:0] P_TXW_H = 5'd4;
  localparam logic [PHASE_W-1:0] P_AKW_L = 5'd5;
  localparam logic [PHASE_W-1:0] P_AKW_H = 5'd6;
  localparam logic [PHASE_W-1:0] P_TXR_L = 5'd7;
  localparam logic [PHASE_W-1:0] P_TXR_H = 5'd8;
  localparam logic [PHASE_W-1:0] P_AKR_L = 5'd9;
  localparam logic [PHASE_W-1:0] P_AKR_H = 5'd10;
  localparam logic [PHASE_W-1:0] P_RS_PRE = 5'd11;
  localparam logic [PHASE_W-1:0] P_RS_HI = 5'd12;
  localparam logic [PHASE_W-1:0] P_RS_LO = 5'd13;
  localparam logic [PHASE_W-1:0] P_TXD_L = 5'd14;
  localparam logic [PHASE_W-1:0] P_TXD_H = 5'd15;
  localparam logic [PHASE_W-1:0] P_AKD_L = 5'd16;
  localparam logic [PHASE_W-1:0] P_AKD_H = 5'd17;
  localparam logic [PHASE_W-1:0] P_RX_L = 5'd18;
  localparam logic [PHASE_W-1:0] P_RX_H = 5'd19;
  localparam logic [PHASE_W-1:0] P_MA_L = 5'd20;
  localparam logic [PHASE_W-1:0] P_MA_H = 5'd21;
  localparam logic [PHASE_W-1:0] P_SP_L = 5'd22;
  localparam logic [PHASE_W-1:0] P_SP_M = 5'd23;
  localparam logic [PHASE_W-1:0] P_SP_H = 5'd24;
  localparam logic [PHASE_W-1:0] P_SE_L = 5'd25;
  localparam logic [PHASE_W-1:0] P_SE_M = 5'd26;
  localparam logic [PHASE_W-1:0] P_SE_H = 5'd27;
  localparam logic [PHASE_W-1:0] NPHASES = 5'd28;

  // sda source of a phase
  typedef enum logic [1:0] {
    SDA_LOW,
    SDA_HIGH,
    SDA_SHIFT
  } sda_src_t;

  function automatic logic scl_of(input logic [PHASE_W-1:0] p);
    logic v;
    case (p) inside
      P_TXW_L, P_AKW_L, P_TXR_L, P_AKR_L, P_TXD_L, P_AKD_L, P_RX_L,
      P_MA_L, P_SP_L, P_SE_L: v = 1'b0;
      default: v = 1'b1;
    endcase
    return v;
  endfunction

  function automatic sda_src_t sda_of(input logic [PHASE_W-1:0] p);
    sda_src_t v;
    case (p) inside
      P_ST_LO, P_RS_LO, P_MA_L, P_MA_H, P_SP_L, P_SP_M,
      P_SE_L, P_SE_M: v = SDA_LOW;
      P_TXW_L, P_TXW_H, P_TXR_L, P_TXR_H, P_TXD_L, P_TXD_H: v = SDA_SHIFT;
      default: v = SDA_HIGH;
    endcase
    return v;
  endfunction

  function automatic logic rel_of(input logic [PHASE_W-1:0] p);
    logic v;
    case (p) inside
      P_AKW_L, P_AKW_H, P_AKR_L, P_AKR_H, P_AKD_L, P_AKD_H,
      P_RX_L, P_RX_H: v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/i2c_register_read_master_core.sv @@
// i2c register read master, top level: request stream in, line and status stream out
// depends on i2crr_pkg and i2c_register_read_master_core_macros.svh
//
// usage
//   s_axis carries one request per cycle at most: tuser is the operation (tick or
//   begin), tdata holds reg_address and the sampled sda level. every request gives
//   exactly one result on m_axis: the scl/sda levels, sda release, busy, done, nack
//   error and the received byte for that tick.
//   a begin while idle latches the register pointer; ticks then walk the bus
//   sequence (start, write address, register byte, repeated start, read address,
//   eight data bits, master ack, stop). a slave that stays high past ack_timeout
//   samples gets a stop and the done result carries nack_error.
//   each result is registered: it goes into the result register, or into the skid while one waits.
//   throughput: one request per cycle while s_axis_tready is high, set by the single
//   next-state pass from the phase register to the result register.
//   a two-entry output (result register plus skid) lets one more request in while
//   a result waits; with both full s_axis_tready drops until m_axis drains.
//   reset (rst, synchronous) returns the sequencer to idle, empties the output and
//   reloads the registers with their reset values. the apb port is to be written only
//   while the block is idle; the block itself does not enforce this.
module i2c_register_read_master_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] reg_address, [8] sda_in, [15:9] zero
  input  logic [i2crr_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // [0] operation
  input  logic [i2crr_pkg::S_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_released, [3] busy_res, [4] done_res,
  // [5] nack_error, [13:6] read_data, [15:14] zero
  output logic [i2crr_pkg::M_DATA_W-1:0]      m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2crr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [i2crr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [i2crr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import i2crr_pkg::*;

  `include "i2c_register_read_master_core_macros.svh"

  // configuration registers
  logic [6:0] device_address;
  logic [7:0] ack_timeout;
  logic [7:0] write_phase_ticks;
  logic [7:0] read_phase_ticks;

  // sequencer state
  logic [PHASE_W-1:0] phase, phase_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] tick_count, tick_count_next;
  logic [7:0] ack_count, ack_count_next;
  logic [7:0] latched_reg, latched_reg_next;

  // output register and skid
  logic [M_DATA_W-1:0] res_next;
  logic [M_DATA_W-1:0] skid_data;
  logic skid_valid;

  logic in_accept, out_take, cfg_wr;
  logic op;
  logic [7:0] in_reg;
  logic in_sda;

  logic [PHASE_W-1:0] p;
  logic [7:0] wbyte;
  logic [7:0] wr_len, rd_len;
  logic wr_hd, rd_hd;
  logic [7:0] cnt_wr, cnt_rd;
  logic [3:0] bit_inc;
  logic line_sda;
  logic done, err;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_DEVICE_ADDRESS: prdata = {25'd0, device_address};
      REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout};
      REG_WRITE_PHASE_TICKS: prdata = {24'd0, write_phase_ticks};
      REG_READ_PHASE_TICKS: prdata = {24'd0, read_phase_ticks};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
      write_phase_ticks <= WRITE_PHASE_TICKS_RST;
      read_phase_ticks <= READ_PHASE_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DEVICE_ADDRESS: device_address <= pwdata[6:0];
        REG_ACK_TIMEOUT: ack_timeout <= pwdata[7:0];
        REG_WRITE_PHASE_TICKS: write_phase_ticks <= pwdata[7:0];
        REG_READ_PHASE_TICKS: read_phase_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !skid_valid;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  assign op = s_axis_tuser[0];
  assign in_reg = s_axis_tdata[7:0];
  assign in_sda = s_axis_tdata[8];

  // codes past the table act as idle
  assign p = (phase < NPHASES) ? phase : P_IDLE;
  assign wbyte = {device_address, 1'b0};

  // a length of zero behaves as one
  assign wr_len = (write_phase_ticks == 8'd0) ? 8'd1 : write_phase_ticks;
  assign rd_len = (read_phase_ticks == 8'd0) ? 8'd1 : read_phase_ticks;
  assign wr_hd = ({1'b0, tick_count} + 9'd1) >= {1'b0, wr_len};
  assign rd_hd = ({1'b0, tick_count} + 9'd1) >= {1'b0, rd_len};
  assign cnt_wr = wr_hd ? 8'd0 : tick_count + 8'd1;
  assign cnt_rd = rd_hd ? 8'd0 : tick_count + 8'd1;
  assign bit_inc = bit_index + 4'd1;

  always_comb begin
    unique case (sda_of(p))
      SDA_LOW: line_sda = 1'b0;
      SDA_SHIFT: line_sda = shift_byte[7];
      default: line_sda = 1'b1;
    endcase
  end

  always_comb begin
    phase_next = phase;
    bit_index_next = bit_index;
    shift_byte_next = shift_byte;
    tick_count_next = tick_count;
    ack_count_next = ack_count;
    latched_reg_next = latched_reg;
    done = 1'b0;
    err = 1'b0;

    if (op == OP_BEGIN) begin
      if (p == P_IDLE) begin
        latched_reg_next = in_reg;
        bit_index_next = 4'd0;
        shift_byte_next = 8'd0;
        phase_next = P_ST_HI;
        tick_count_next = 8'd0;
        ack_count_next = 8'd0;
      end
    end else begin
      unique case (p)
        P_ST_HI, P_ST_LO, P_TXW_L, P_AKW_L, P_TXR_L, P_AKR_L, P_RS_PRE, P_RS_HI,
        P_RS_LO, P_TXD_L, P_AKD_L, P_MA_L, P_MA_H, P_SP_L, P_SP_M, P_SP_H,
        P_SE_L, P_SE_M, P_SE_H: begin
          tick_count_next = cnt_wr;
          if (wr_hd) begin
            ack_count_next = 8'd0;
            phase_next = p + 5'd1;
            case (p)
              P_ST_LO: begin
                shift_byte_next = wbyte;
                bit_index_next = 4'd0;
              end
              P_RS_LO: begin
                shift_byte_next = wbyte | 8'd1;
                bit_index_next = 4'd0;
              end
              P_MA_H: phase_next = P_SP_L;
              P_SP_H: begin
                phase_next = P_IDLE;
                done = 1'b1;
              end
              P_SE_H: begin
                phase_next = P_IDLE;
                done = 1'b1;
                err = 1'b1;
              end
              default: ;
            endcase
          end
        end
        // high half of a sent bit
        P_TXW_H, P_TXR_H, P_TXD_H: begin
          tick_count_next = cnt_wr;
          if (wr_hd) begin
            ack_count_next = 8'd0;
            shift_byte_next = {shift_byte[6:0], 1'b0};
            if (bit_inc >= 4'd8) begin
              bit_index_next = 4'd0;
              phase_next = p + 5'd1;
            end else begin
              bit_index_next = bit_inc;
              phase_next = p - 5'd1;
            end
          end
        end
        // ack wait, sda sampled every tick
        P_AKW_H, P_AKR_H, P_AKD_H: begin
          if (!in_sda) begin
            tick_count_next = 8'd0;
            ack_count_next = 8'd0;
            case (p)
              P_AKW_H: begin
                phase_next = P_TXR_L;
                shift_byte_next = latched_reg;
                bit_index_next = 4'd0;
              end
              P_AKR_H: phase_next = P_RS_PRE;
              default: begin
                phase_next = P_RX_L;
                shift_byte_next = 8'd0;
                bit_index_next = 4'd0;
              end
            endcase
          end else if (ack_count >= ack_timeout) begin
            phase_next = P_SE_L;
            tick_count_next = 8'd0;
            ack_count_next = 8'd0;
          end else begin
            ack_count_next = ack_count + 8'd1;
          end
        end
        P_RX_L: begin
          tick_count_next = cnt_rd;
          if (rd_hd) begin
            phase_next = P_RX_H;
            ack_count_next = 8'd0;
          end
        end
        P_RX_H: begin
          // sample on the first tick of the high half
          if (tick_count == 8'd0) begin
            shift_byte_next = {shift_byte[6:0], in_sda};
          end
          tick_count_next = cnt_rd;
          if (rd_hd) begin
            ack_count_next = 8'd0;
            if (bit_inc >= 4'd8) begin
              bit_index_next = 4'd0;
              phase_next = P_MA_L;
            end else begin
              bit_index_next = bit_inc;
              phase_next = P_RX_L;
            end
          end
        end
        default: phase_next = P_IDLE;
      endcase
    end
  end

  always_comb begin
    res_next = '0;
    res_next[0] = scl_of(p);
    res_next[1] = line_sda;
    res_next[2] = rel_of(p);
    res_next[3] = (p != P_IDLE) || (op == OP_BEGIN);
    if (done) begin
      res_next[3] = 1'b0;
      res_next[4] = 1'b1;
      res_next[5] = err;
      res_next[13:6] = err ? 8'd0 : shift_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      bit_index <= 4'd0;
      shift_byte <= 8'd0;
      tick_count <= 8'd0;
      ack_count <= 8'd0;
      latched_reg <= 8'd0;
    end else if (in_accept) begin
      phase <= phase_next;
      bit_index <= bit_index_next;
      shift_byte <= shift_byte_next;
      tick_count <= tick_count_next;
      ack_count <= ack_count_next;
      latched_reg <= latched_reg_next;
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      if (!m_axis_tvalid || out_take) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!m_axis_tvalid || out_take) begin
        m_axis_tdata <= res_next;
      end else begin
        skid_data <= res_next;
      end
    end else if (out_take && skid_valid) begin
      m_axis_tdata <= skid_data;
    end
  end

  `I2CRR_ASSERT(a_skid_behind_out, skid_valid |-> m_axis_tvalid, "skid full with empty output")
  `I2CRR_ASSERT(a_done_not_busy, (m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tdata[3], "done result still busy")
  `I2CRR_ASSERT(a_nack_no_data, (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[13:6] == 8'd0), "nack result carries data")
  `I2CRR_ASSERT_ALWAYS(a_reset_empties, rst |=> (!m_axis_tvalid && !skid_valid), "not empty after reset")

endmodule

@@ dv/i2c_register_read_master_core_tb.sv @@
// testbench for the i2c register read master core: tick and begin requests in,
// one line/status result out per request, checked against an in-bench bus sequencer
// depends on i2crr_pkg and i2c_register_read_master_core
module i2c_register_read_master_core_tb;
  import i2crr_pkg::*;

  localparam int LIMIT = 500000;
  localparam int TOTAL_ITEMS = 1550;
  localparam int IDLE_PCT = 11;

  // which acknowledge a transfer leaves unanswered
  localparam int NO_FAIL = -1;
  localparam int ACK_ADDR_W = 0;
  localparam int ACK_REG = 1;
  localparam int ACK_ADDR_R = 2;

  // same bit order as m_axis_tdata[13:0]
  typedef struct packed {
    logic [7:0] read_data;
    logic       nack_error;
    logic       done_res;
    logic       busy_res;
    logic       sda_released;
    logic       sda_level;
    logic       scl_level;
  } line_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic m_tready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;

  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  i2c_register_read_master_core DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_tdata),
    .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  line_t pending_lines[$];
  int n_fail = 0;
  int cycles = 0;
  int items_sent = 0;
  logic no_idle = 1'b0;
  int rx_hold_req = 0;
  int rx_hold_seen = 0;
  int rx_hold_len = 0;
  int rx_stall_left = 0;

  // bus sequencer state and register copies
  logic [PHASE_W-1:0] seq_phase;
  logic [3:0] bit_pos;
  logic [7:0] shreg;
  logic [7:0] half_cnt;
  logic [7:0] ack_cnt;
  logic [7:0] reg_ptr;
  logic [6:0] dev_addr;
  logic [7:0] ack_limit;
  logic [7:0] wr_half;
  logic [7:0] rd_half;

  task automatic seq_reset;
    dev_addr = DEVICE_ADDRESS_RST;
    ack_limit = ACK_TIMEOUT_RST;
    wr_half = WRITE_PHASE_TICKS_RST;
    rd_half = READ_PHASE_TICKS_RST;
    seq_phase = P_IDLE;
    bit_pos = '0;
    shreg = '0;
    half_cnt = '0;
    ack_cnt = '0;
    reg_ptr = '0;
  endtask

  function automatic void enter(input logic [PHASE_W-1:0] p);
    seq_phase = p;
    half_cnt = '0;
    ack_cnt = '0;
  endfunction

  function automatic void load_byte(input logic [PHASE_W-1:0] p, input logic [7:0] b);
    shreg = b;
    bit_pos = '0;
    enter(p);
  endfunction

  // a length of zero counts as one tick
  function automatic logic half_over(input logic [7:0] len);
    logic [8:0] n;
    n = (len == 8'd0) ? 9'd1 : {1'b0, len};
    if ({1'b0, half_cnt} + 9'd1 >= n) begin
      half_cnt = '0;
      return 1'b1;
    end
    half_cnt = half_cnt + 8'd1;
    return 1'b0;
  endfunction

  function automatic void bit_sent(input logic [PHASE_W-1:0] low_p,
                                   input logic [PHASE_W-1:0] ack_p);
    shreg = shreg << 1;
    bit_pos = bit_pos + 4'd1;
    if (bit_pos >= 4'd8) begin
      bit_pos = '0;
      enter(ack_p);
    end else begin
      enter(low_p);
    end
  endfunction

  function automatic logic ack_seen(input logic sda);
    if (!sda) return 1'b1;
    if (ack_cnt >= ack_limit) enter(P_SE_L);
    else ack_cnt = ack_cnt + 8'd1;
    return 1'b0;
  endfunction

  task automatic bus_step(input logic op, input logic [7:0] regv, input logic sda_in,
                          output line_t r);
    logic [PHASE_W-1:0] p;
    logic [7:0] wbyte;
    logic fin;
    logic err;
    p = (seq_phase < NPHASES) ? seq_phase : P_IDLE;
    wbyte = {dev_addr, 1'b0};
    fin = 1'b0;
    err = 1'b0;
    r = '0;
    case (p)
      P_TXW_L, P_AKW_L, P_TXR_L, P_AKR_L, P_TXD_L, P_AKD_L, P_RX_L, P_MA_L, P_SP_L,
      P_SE_L: r.scl_level = 1'b0;
      default: r.scl_level = 1'b1;
    endcase
    case (p)
      P_ST_LO, P_RS_LO, P_MA_L, P_MA_H, P_SP_L, P_SP_M, P_SE_L, P_SE_M:
        r.sda_level = 1'b0;
      P_TXW_L, P_TXW_H, P_TXR_L, P_TXR_H, P_TXD_L, P_TXD_H: r.sda_level = shreg[7];
      default: r.sda_level = 1'b1;
    endcase
    case (p)
      P_AKW_L, P_AKW_H, P_AKR_L, P_AKR_H, P_AKD_L, P_AKD_H, P_RX_L, P_RX_H:
        r.sda_released = 1'b1;
      default: r.sda_released = 1'b0;
    endcase
    r.busy_res = (p != P_IDLE);

    if (op == OP_BEGIN) begin
      // a begin while busy changes nothing
      if (p == P_IDLE) begin
        reg_ptr = regv;
        bit_pos = '0;
        shreg = '0;
        enter(P_ST_HI);
        r.busy_res = 1'b1;
      end
    end else begin
      case (p)
        P_ST_HI: if (half_over(wr_half)) enter(P_ST_LO);
        P_ST_LO: if (half_over(wr_half)) load_byte(P_TXW_L, wbyte);
        P_TXW_L: if (half_over(wr_half)) enter(P_TXW_H);
        P_TXW_H: if (half_over(wr_half)) bit_sent(P_TXW_L, P_AKW_L);
        P_AKW_L: if (half_over(wr_half)) enter(P_AKW_H);
        P_AKW_H: if (ack_seen(sda_in)) load_byte(P_TXR_L, reg_ptr);
        P_TXR_L: if (half_over(wr_half)) enter(P_TXR_H);
        P_TXR_H: if (half_over(wr_half)) bit_sent(P_TXR_L, P_AKR_L);
        P_AKR_L: if (half_over(wr_half)) enter(P_AKR_H);
        P_AKR_H: if (ack_seen(sda_in)) enter(P_RS_PRE);
        P_RS_PRE: if (half_over(wr_half)) enter(P_RS_HI);
        P_RS_HI: if (half_over(wr_half)) enter(P_RS_LO);
        P_RS_LO: if (half_over(wr_half)) load_byte(P_TXD_L, wbyte | 8'd1);
        P_TXD_L: if (half_over(wr_half)) enter(P_TXD_H);
        P_TXD_H: if (half_over(wr_half)) bit_sent(P_TXD_L, P_AKD_L);
        P_AKD_L: if (half_over(wr_half)) enter(P_AKD_H);
        P_AKD_H: if (ack_seen(sda_in)) load_byte(P_RX_L, 8'd0);
        P_RX_L: if (half_over(rd_half)) enter(P_RX_H);
        P_RX_H: begin
          // data bit taken on the first tick of the high half
          if (half_cnt == 8'd0) shreg = {shreg[6:0], sda_in};
          if (half_over(rd_half)) begin
            bit_pos = bit_pos + 4'd1;
            if (bit_pos >= 4'd8) begin
              bit_pos = '0;
              enter(P_MA_L);
            end else begin
              enter(P_RX_L);
            end
          end
        end
        P_MA_L: if (half_over(wr_half)) enter(P_MA_H);
        P_MA_H: if (half_over(wr_half)) enter(P_SP_L);
        P_SP_L: if (half_over(wr_half)) enter(P_SP_M);
        P_SP_M: if (half_over(wr_half)) enter(P_SP_H);
        P_SP_H: if (half_over(wr_half)) begin
          enter(P_IDLE);
          fin = 1'b1;
        end
        P_SE_L: if (half_over(wr_half)) enter(P_SE_M);
        P_SE_M: if (half_over(wr_half)) enter(P_SE_H);
        P_SE_H: if (half_over(wr_half)) begin
          enter(P_IDLE);
          fin = 1'b1;
          err = 1'b1;
        end
        default: seq_phase = P_IDLE;
      endcase
    end

    if (fin) begin
      r.busy_res = 1'b0;
      r.done_res = 1'b1;
      r.nack_error = err;
      r.read_data = err ? 8'd0 : shreg;
    end
  endtask

  // sender: one request per call, random gaps unless no_idle is set
  task automatic send_req(input logic op, input logic [7:0] regv, input logic sda);
    line_t r;
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(S_DATA_W-9){1'b0}}, sda, regv};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bus_step(op, regv, sda, r);
    pending_lines.push_back(r);
    items_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DEVICE_ADDRESS: dev_addr = val[6:0];
      REG_ACK_TIMEOUT: ack_limit = val[7:0];
      REG_WRITE_PHASE_TICKS: wr_half = val[7:0];
      REG_READ_PHASE_TICKS: rd_half = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // slave side of the line: acks held high for a while or forever, random data
  function automatic logic slave_sda(input int fail_ack, input int late);
    int which;
    case (seq_phase)
      P_AKW_H: which = ACK_ADDR_W;
      P_AKR_H: which = ACK_REG;
      P_AKD_H: which = ACK_ADDR_R;
      default: which = NO_FAIL;
    endcase
    if (which == NO_FAIL) return 1'($urandom_range(1));
    if (which == fail_ack) return 1'b1;
    return (int'(ack_cnt) < late) && (ack_cnt < ack_limit);
  endfunction

  // one register read from begin until the sequencer is idle again
  task automatic run_read(input logic [7:0] regv, input int fail_ack, input int late,
                          input int noise_pct, input int pause_after);
    int n;
    n = 0;
    send_req(OP_BEGIN, regv, 1'($urandom_range(1)));
    while (seq_phase != P_IDLE) begin
      if (n == pause_after) begin
        // sender holds back until every result is out
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_lines.size() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < noise_pct)
        send_req(OP_BEGIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else
        send_req(OP_TICK, 8'($urandom_range(255)), slave_sda(fail_ack, late));
      n++;
    end
  endtask

  task automatic test_idle_and_begin;
    send_req(OP_TICK, 8'h00, 1'b0);
    send_req(OP_TICK, 8'hFF, 1'b1);
    run_read(8'hFF, NO_FAIL, 0, 10, -1);
    drain();
  endtask

  task automatic test_device_address;
    cfg_write(REG_READ_PHASE_TICKS, 32'd1);
    cfg_write(REG_DEVICE_ADDRESS, 32'd0);
    run_read(8'hA5, NO_FAIL, 1, 0, -1);
    drain();
    cfg_write(REG_DEVICE_ADDRESS, 32'd127);
    run_read(8'h5A, NO_FAIL, 0, 5, -1);
    drain();
  endtask

  task automatic test_ack_timeout;
    cfg_write(REG_ACK_TIMEOUT, 32'd1);
    run_read(8'h11, ACK_ADDR_W, 0, 0, -1);
    run_read(8'h22, ACK_REG, 1, 0, -1);
    run_read(8'h33, ACK_ADDR_R, 1, 0, -1);
    drain();
    // held high up to the last sample the limit allows
    cfg_write(REG_ACK_TIMEOUT, 32'd12);
    run_read(8'h44, NO_FAIL, 12, 0, -1);
    drain();
    // a limit of zero aborts on the first high sample
    cfg_write(REG_ACK_TIMEOUT, 32'd0);
    run_read(8'h77, ACK_REG, 0, 0, -1);
    drain();
  endtask

  task automatic test_half_periods;
    cfg_write(REG_ACK_TIMEOUT, 32'd2);
    cfg_write(REG_WRITE_PHASE_TICKS, 32'd0);
    cfg_write(REG_READ_PHASE_TICKS, 32'd0);
    run_read(8'hC3, NO_FAIL, 2, 0, -1);
    drain();
    cfg_write(REG_WRITE_PHASE_TICKS, 32'd2);
    cfg_write(REG_READ_PHASE_TICKS, 32'd1);
    run_read(8'h3C, NO_FAIL, 1, 3, -1);
    drain();
    cfg_write(REG_WRITE_PHASE_TICKS, 32'd1);
    cfg_write(REG_READ_PHASE_TICKS, 32'd3);
    run_read(8'h81, NO_FAIL, 0, 0, -1);
    drain();
    // long write half period, cut short by a missing address ack
    cfg_write(REG_WRITE_PHASE_TICKS, 32'd5);
    cfg_write(REG_ACK_TIMEOUT, 32'd1);
    run_read(8'h7E, ACK_ADDR_W, 0, 0, -1);
    drain();
    cfg_write(REG_WRITE_PHASE_TICKS, 32'd1);
    cfg_write(REG_READ_PHASE_TICKS, 32'd2);
    cfg_write(REG_ACK_TIMEOUT, 32'd4);
  endtask

  task automatic test_backpressure;
    rx_hold_len <= 60;
    rx_hold_req <= rx_hold_req + 1;
    run_read(8'h96, NO_FAIL, 2, 0, 40);
    drain();
  endtask

  task automatic test_random;
    int txn;
    int fail_ack;
    int late;
    txn = 0;
    while (items_sent < TOTAL_ITEMS) begin
      // every fifth transfer runs without gaps on either side
      no_idle <= (txn % 5 == 1);
      if ($urandom_range(1)) begin
        drain();
        cfg_write(REG_DEVICE_ADDRESS, $urandom_range(127));
        cfg_write(REG_ACK_TIMEOUT,
                  ($urandom_range(9) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 255));
        cfg_write(REG_WRITE_PHASE_TICKS, $urandom_range(1, 3));
        cfg_write(REG_READ_PHASE_TICKS, $urandom_range(1, 4));
      end
      repeat ($urandom_range(0, 3))
        send_req(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      fail_ack = ($urandom_range(9) < 2) ? int'($urandom_range(ACK_ADDR_W, ACK_ADDR_R))
                                         : NO_FAIL;
      late = ($urandom_range(3) == 0) ? int'($urandom_range(0, 4)) : 0;
      run_read(8'($urandom_range(255)), fail_ack, late, 3, -1);
      txn++;
    end
    no_idle <= 1'b0;
    drain();
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_stall_left <= rx_hold_len;
      m_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_tready <= 1'b0;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want != got) begin
      $error("%s mismatch: expected %0h actual %0h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : result_check
    line_t want;
    line_t got;
    if (!rst && m_axis_tvalid && m_tready) begin
      got = line_t'(m_axis_tdata[13:0]);
      if (pending_lines.size() == 0) begin
        $error("result with no request waiting: %h", m_axis_tdata);
        n_fail++;
      end else begin
        want = pending_lines.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
        check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
        check_field("sda_released", 8'(want.sda_released), 8'(got.sda_released));
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("nack_error", 8'(want.nack_error), 8'(got.nack_error));
        check_field("read_data", want.read_data, got.read_data);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    seq_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_and_begin();
    test_device_address();
    test_ack_timeout();
    test_half_periods();
    test_backpressure();
    test_random();
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
